[src/assert_macros.svh]
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, quiet while reset is high.
`define SRTA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs through reset.
`define SRTA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/srta_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package srta_pkg;

  localparam int KIND_W  = 2;
  localparam int ROW_W   = 6;
  localparam int COL_W   = 10;
  localparam int DATA_W  = 32;
  localparam int TOTAL_W = 11;

  typedef enum logic [1:0] {
    KIND_SET  = 2'd0,
    KIND_ADD  = 2'd1,
    KIND_READ = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_SEARCH,
    ST_DECIDE,
    ST_SHIFT,
    ST_INSERT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0]  read_value;
    logic               found;
    logic               row_full;
    logic               saturated;
    logic [TOTAL_W-1:0] entry_total;
  } result_t;

endpackage

`default_nettype wire

[src/srta_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module srta_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/srta_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module srta_ctrl #(
  parameter int ROWS = 64,
  parameter int ROW_CAPACITY = 16,
  parameter int COLUMNS = 1024,
  parameter int VALUE_BITS = 32,
  localparam int SLOTS = ROWS * ROW_CAPACITY,
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1,
  localparam int KW = $clog2(ROW_CAPACITY + 1),
  localparam int TW = $clog2(SLOTS + 1),
  localparam int EW = ((VALUE_BITS > 32) ? VALUE_BITS : 32) + 1,
  localparam int WW = srta_pkg::COL_W + VALUE_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    idle,
  input  wire logic [srta_pkg::KIND_W-1:0]        in_kind,
  input  wire logic [srta_pkg::ROW_W-1:0]         in_row,
  input  wire logic [srta_pkg::COL_W-1:0]         in_column,
  input  wire logic signed [srta_pkg::DATA_W-1:0] in_operand,
  output logic                                    res_valid,
  input  wire logic                               res_take,
  output srta_pkg::result_t                       res,
  output logic                                    ent_we,
  output logic [AW-1:0]                           ent_waddr,
  output logic [WW-1:0]                           ent_wdata,
  output logic [AW-1:0]                           ent_raddr,
  input  wire logic [WW-1:0]                      ent_rdata,
  output logic                                    fill_we,
  output logic [RW-1:0]                           fill_waddr,
  output logic [KW-1:0]                           fill_wdata,
  output logic [RW-1:0]                           fill_raddr,
  input  wire logic [KW-1:0]                      fill_rdata
);

  import srta_pkg::*;

  localparam logic signed [EW-1:0] VMAX =
    {{(EW - VALUE_BITS + 1){1'b0}}, {(VALUE_BITS - 1){1'b1}}};
  localparam logic signed [EW-1:0] VMIN = ~VMAX;

  function automatic logic signed [EW-1:0] sx(input logic [VALUE_BITS-1:0] v);
    return {{(EW - VALUE_BITS){v[VALUE_BITS-1]}}, v};
  endfunction

  // {clipped flag, value}
  function automatic logic [VALUE_BITS:0] clip_val(input logic signed [EW-1:0] v);
    logic [VALUE_BITS:0] r;
    if (v > VMAX) begin
      r = {1'b1, VMAX[VALUE_BITS-1:0]};
    end else if (v < VMIN) begin
      r = {1'b1, VMIN[VALUE_BITS-1:0]};
    end else begin
      r = {1'b0, v[VALUE_BITS-1:0]};
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] to_out(input logic [VALUE_BITS-1:0] v);
    logic [EW-1:0] t;
    t = sx(v);
    return t[DATA_W-1:0];
  endfunction

  state_t state, state_next;

  logic [KIND_W-1:0]     kind_q;
  logic [ROW_W-1:0]      row_q;
  logic [COL_W-1:0]      col_q;
  logic [VALUE_BITS-1:0] op_q;
  logic                  op_sat_q;
  logic                  in_range_q;
  logic [AW-1:0]         base_q;
  logic [KW-1:0]         fill_q, fill_next;
  logic [KW-1:0]         lo_q, lo_next;
  logic [KW-1:0]         hi_q, hi_next;
  logic [KW-1:0]         mid_q, mid_next;
  logic [KW-1:0]         k_q, k_next;
  logic [KW-1:0]         m_q, m_next;
  logic                  found_q, found_next;
  logic [VALUE_BITS-1:0] val_q, val_next;
  logic [RW-1:0]         clr_q, clr_next;
  logic [TW-1:0]         total_q, total_next;
  result_t               res_q, res_next;

  logic                  accept;
  logic [VALUE_BITS:0]   op_clip;
  logic                  in_range;
  logic [KW-1:0]         rd_idx;
  logic [KW-1:0]         nlo, nhi, fcap;
  logic [KW:0]           msum;
  logic [COL_W-1:0]      ent_col;
  logic signed [EW-1:0]  sum;
  logic [VALUE_BITS:0]   upd;
  logic [VALUE_BITS-1:0] newv;
  logic                  newsat;

  assign idle       = (state == ST_IDLE);
  assign res_valid  = (state == ST_DONE);
  assign res        = res_q;
  assign accept     = idle && in_valid;
  assign fill_raddr = RW'(in_row);
  assign ent_raddr  = base_q + AW'(rd_idx);
  assign ent_col    = ent_rdata[WW-1 -: COL_W];
  assign op_clip    = clip_val({{(EW - DATA_W){in_operand[DATA_W-1]}}, in_operand});
  assign in_range   = (32'(in_row) < 32'(ROWS)) && (32'(in_column) < 32'(COLUMNS));
  assign sum        = sx(val_q) + sx(op_q);
  assign upd        = clip_val(sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_q   <= '0;
      total_q <= '0;
    end else begin
      state   <= state_next;
      clr_q   <= clr_next;
      total_q <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q               <= in_kind;
      row_q                <= in_row;
      col_q                <= in_column;
      {op_sat_q, op_q}     <= op_clip;
      in_range_q           <= in_range;
      base_q               <= AW'(in_row) * AW'(ROW_CAPACITY);
    end
    fill_q  <= fill_next;
    lo_q    <= lo_next;
    hi_q    <= hi_next;
    mid_q   <= mid_next;
    k_q     <= k_next;
    m_q     <= m_next;
    found_q <= found_next;
    val_q   <= val_next;
    res_q   <= res_next;
  end

  // Items never overlap, so each read sees every earlier write.
  always_comb begin
    state_next = state;
    fill_next  = fill_q;
    lo_next    = lo_q;
    hi_next    = hi_q;
    mid_next   = mid_q;
    k_next     = k_q;
    m_next     = m_q;
    found_next = found_q;
    val_next   = val_q;
    clr_next   = clr_q;
    total_next = total_q;
    res_next   = res_q;
    rd_idx     = '0;
    ent_we     = 1'b0;
    ent_waddr  = base_q + AW'(k_q);
    ent_wdata  = {col_q, op_q};
    fill_we    = 1'b0;
    fill_waddr = RW'(row_q);
    fill_wdata = fill_q + KW'(1);
    nlo        = lo_q;
    nhi        = hi_q;
    msum       = '0;
    fcap       = '0;
    newv       = op_q;
    newsat     = op_sat_q;

    case (state)
      ST_CLEAR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_q;
        fill_wdata = '0;
        clr_next   = clr_q + RW'(1);
        if (clr_q == RW'(ROWS - 1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_FILL;
        end
      end

      ST_FILL: begin
        fcap       = (fill_rdata > KW'(ROW_CAPACITY)) ? KW'(ROW_CAPACITY) : fill_rdata;
        fill_next  = fcap;
        found_next = 1'b0;
        k_next     = '0;
        lo_next    = '0;
        hi_next    = fcap;
        if (in_range_q && fcap != '0) begin
          rd_idx     = fcap >> 1;
          mid_next   = fcap >> 1;
          state_next = ST_SEARCH;
        end else begin
          state_next = ST_DECIDE;
        end
      end

      ST_SEARCH: begin
        if (ent_col == col_q) begin
          found_next = 1'b1;
          k_next     = mid_q;
          val_next   = ent_rdata[VALUE_BITS-1:0];
          state_next = ST_DECIDE;
        end else begin
          if (ent_col < col_q) begin
            nlo = mid_q + KW'(1);
          end else begin
            nhi = mid_q;
          end
          lo_next = nlo;
          hi_next = nhi;
          if (nlo < nhi) begin
            msum     = {1'b0, nlo} + {1'b0, nhi};
            rd_idx   = msum[KW:1];
            mid_next = msum[KW:1];
          end else begin
            k_next     = nlo;
            state_next = ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        res_next.read_value  = '0;
        res_next.found       = 1'b0;
        res_next.row_full    = 1'b0;
        res_next.saturated   = 1'b0;
        res_next.entry_total = TOTAL_W'(total_q);
        state_next           = ST_DONE;
        if (in_range_q) begin
          res_next.found = found_q;
          case (kind_q)
            KIND_SET, KIND_ADD: begin
              if (kind_q == KIND_ADD && op_q == '0) begin
                res_next.read_value = found_q ? to_out(val_q) : '0;
                res_next.saturated  = op_sat_q;
              end else if (found_q) begin
                if (kind_q == KIND_ADD) begin
                  newv   = upd[VALUE_BITS-1:0];
                  newsat = op_sat_q | upd[VALUE_BITS];
                end
                ent_we              = 1'b1;
                ent_wdata           = {col_q, newv};
                res_next.read_value = to_out(newv);
                res_next.saturated  = newsat;
              end else if (fill_q >= KW'(ROW_CAPACITY)) begin
                res_next.row_full = 1'b1;
              end else if (fill_q > k_q) begin
                rd_idx     = fill_q - KW'(1);
                m_next     = fill_q;
                state_next = ST_SHIFT;
              end else begin
                state_next = ST_INSERT;
              end
            end
            default: begin
              res_next.read_value = found_q ? to_out(val_q) : '0;
            end
          endcase
        end
      end

      ST_SHIFT: begin
        ent_we    = 1'b1;
        ent_waddr = base_q + AW'(m_q);
        ent_wdata = ent_rdata;
        m_next    = m_q - KW'(1);
        if ((m_q - KW'(1)) > k_q) begin
          rd_idx = m_q - KW'(2);
        end else begin
          state_next = ST_INSERT;
        end
      end

      ST_INSERT: begin
        ent_we               = 1'b1;
        fill_we              = 1'b1;
        total_next           = total_q + TW'(1);
        res_next.read_value  = to_out(op_q);
        res_next.found       = 1'b0;
        res_next.row_full    = 1'b0;
        res_next.saturated   = op_sat_q;
        res_next.entry_total = TOTAL_W'(total_q + TW'(1));
        state_next           = ST_DONE;
      end

      ST_DONE: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `SRTA_ASSERT(a_search_window, clk, rst, (state == ST_SEARCH) |-> (lo_q < hi_q), "search window empty")
  `SRTA_ASSERT(a_shift_above_k, clk, rst, (state == ST_SHIFT) |-> (m_q > k_q), "shift below insert point")
  `SRTA_ASSERT(a_fill_bound, clk, rst, (state == ST_FILL && in_range_q) |-> (fill_rdata <= KW'(ROW_CAPACITY)), "row fill beyond capacity")
  `SRTA_ASSERT(a_total_step, clk, rst, (state != ST_INSERT) |=> $stable(total_q), "entry total moved outside insert")
  `SRTA_ASSERT_ALWAYS(a_reset_clear, clk, rst |=> (state == ST_CLEAR), "no clearing pass after reset")

endmodule

`default_nettype wire

[src/sparse_row_table_accumulator_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake           Beat
// in       in_valid/in_stall   kind, row, column, operand_value
// out      out_valid/out_stall read_value, found, row_full, saturated, entry_total
//
// One item at a time: a new item is taken only after the last result leaves ST_DONE.
// Each item passes ST_FILL, S = binary search probes (at most clog2(ROW_CAPACITY+1)),
// ST_DECIDE, H = entries shifted (at most ROW_CAPACITY-1) and ST_INSERT on insert.
// After reset a clearing pass zeroes the row fill counts; no beat is taken
// meanwhile. A result waits in the output register under out_stall while the
// next item is already taken and worked on.

module sparse_row_table_accumulator_core #(
  parameter int ROWS = 64,
  parameter int ROW_CAPACITY = 16,
  parameter int COLUMNS = 1024,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [srta_pkg::KIND_W-1:0]         kind,
  input  wire logic [srta_pkg::ROW_W-1:0]          row,
  input  wire logic [srta_pkg::COL_W-1:0]          column,
  input  wire logic signed [srta_pkg::DATA_W-1:0]  operand_value,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [srta_pkg::DATA_W-1:0]       read_value,
  output logic                                     found,
  output logic                                     row_full,
  output logic                                     saturated,
  output logic [srta_pkg::TOTAL_W-1:0]             entry_total
);

  import srta_pkg::*;

  localparam int SLOTS = ROWS * ROW_CAPACITY;
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int KW = $clog2(ROW_CAPACITY + 1);
  localparam int WW = COL_W + VALUE_BITS;

  logic          idle;
  logic          res_valid;
  logic          res_take;
  result_t       res;
  result_t       out_q;
  logic          ent_we;
  logic [AW-1:0] ent_waddr;
  logic [WW-1:0] ent_wdata;
  logic [AW-1:0] ent_raddr;
  logic [WW-1:0] ent_rdata;
  logic          fill_we;
  logic [RW-1:0] fill_waddr;
  logic [KW-1:0] fill_wdata;
  logic [RW-1:0] fill_raddr;
  logic [KW-1:0] fill_rdata;

  assign in_stall = !idle;
  assign res_take = !out_valid || !out_stall;

  srta_ctrl #(
    .ROWS(ROWS),
    .ROW_CAPACITY(ROW_CAPACITY),
    .COLUMNS(COLUMNS),
    .VALUE_BITS(VALUE_BITS)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .idle(idle),
    .in_kind(kind),
    .in_row(row),
    .in_column(column),
    .in_operand(operand_value),
    .res_valid(res_valid),
    .res_take(res_take),
    .res(res),
    .ent_we(ent_we),
    .ent_waddr(ent_waddr),
    .ent_wdata(ent_wdata),
    .ent_raddr(ent_raddr),
    .ent_rdata(ent_rdata),
    .fill_we(fill_we),
    .fill_waddr(fill_waddr),
    .fill_wdata(fill_wdata),
    .fill_raddr(fill_raddr),
    .fill_rdata(fill_rdata)
  );

  srta_ram #(
    .DEPTH(SLOTS),
    .WIDTH(WW)
  ) u_entry_ram (
    .clk(clk),
    .we(ent_we),
    .waddr(ent_waddr),
    .wdata(ent_wdata),
    .raddr(ent_raddr),
    .rdata(ent_rdata)
  );

  srta_ram #(
    .DEPTH(ROWS),
    .WIDTH(KW)
  ) u_fill_ram (
    .clk(clk),
    .we(fill_we),
    .waddr(fill_waddr),
    .wdata(fill_wdata),
    .raddr(fill_raddr),
    .rdata(fill_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_q <= res;
    end
  end

  assign read_value  = out_q.read_value;
  assign found       = out_q.found;
  assign row_full    = out_q.row_full;
  assign saturated   = out_q.saturated;
  assign entry_total = out_q.entry_total;

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import srta_pkg::*;

  localparam int ROWS = 64;
  localparam int ROW_CAP = 16;
  localparam int COLUMNS = 1024;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh80000000;
  localparam logic signed [DATA_W-1:0] VAL_ONE = 32'sh00010000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [KIND_W-1:0] kind = '0;
  logic [ROW_W-1:0] row = '0;
  logic [COL_W-1:0] column = '0;
  logic signed [DATA_W-1:0] operand_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DATA_W-1:0] read_value;
  logic found;
  logic row_full;
  logic saturated;
  logic [TOTAL_W-1:0] entry_total;

  // Shadow copy of the table
  logic [COL_W-1:0] row_cols [ROWS][ROW_CAP];
  logic signed [DATA_W-1:0] row_vals [ROWS][ROW_CAP];
  int row_count [ROWS];
  int stored_total = 0;
  result_t pending_results [$];
  result_t want;

  bit calm = 1'b0;
  int errors = 0;
  int items_sent = 0;
  int results_checked = 0;
  int refused = 0;
  int clipped = 0;
  int quiet_cycles = 0;

  sparse_row_table_accumulator_core u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .row(row),
    .column(column),
    .operand_value(operand_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .read_value(read_value),
    .found(found),
    .row_full(row_full),
    .saturated(saturated),
    .entry_total(entry_total)
  );

  always #5 clk = ~clk;

  function automatic result_t apply_entry_op(logic [KIND_W-1:0] k, logic [ROW_W-1:0] r,
                                             logic [COL_W-1:0] c,
                                             logic signed [DATA_W-1:0] v);
    result_t res;
    int n;
    int pos;
    int m;
    logic hit;
    logic [DATA_W:0] sum;
    res = '0;
    n = row_count[r];
    pos = 0;
    while (pos < n && row_cols[r][pos] < c) pos++;
    hit = (pos < n) && (row_cols[r][pos] == c);
    if (k == KIND_SET || k == KIND_ADD) begin
      if (k == KIND_ADD && v == 0) begin
        if (hit) res.read_value = row_vals[r][pos];
      end else if (hit) begin
        if (k == KIND_ADD) begin
          sum = {row_vals[r][pos][DATA_W-1], row_vals[r][pos]} + {v[DATA_W-1], v};
          if (sum[DATA_W] != sum[DATA_W-1]) begin
            res.saturated = 1'b1;
            row_vals[r][pos] = sum[DATA_W] ? VAL_MIN : VAL_MAX;
          end else begin
            row_vals[r][pos] = sum[DATA_W-1:0];
          end
        end else begin
          row_vals[r][pos] = v;
        end
        res.read_value = row_vals[r][pos];
      end else if (n >= ROW_CAP) begin
        res.row_full = 1'b1;
      end else begin
        for (m = n; m > pos; m--) begin
          row_cols[r][m] = row_cols[r][m-1];
          row_vals[r][m] = row_vals[r][m-1];
        end
        row_cols[r][pos] = c;
        row_vals[r][pos] = v;
        row_count[r] = n + 1;
        stored_total++;
        res.read_value = v;
      end
    end else if (hit) begin
      res.read_value = row_vals[r][pos];
    end
    res.found = hit;
    res.entry_total = TOTAL_W'(stored_total);
    return res;
  endfunction

  task automatic send_op(input logic [KIND_W-1:0] k, input logic [ROW_W-1:0] r,
                         input logic [COL_W-1:0] c, input logic signed [DATA_W-1:0] v);
    result_t res;
    if (!calm && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    row <= r;
    column <= c;
    operand_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = apply_entry_op(k, r, c, v);
    pending_results.push_back(res);
    items_sent++;
    if (res.row_full) refused++;
    if (res.saturated) clipped++;
  endtask

  task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] exp_val);
    $display("tb_top: mismatch on %s, result %0d: got %h, want %h",
             field, results_checked, got, exp_val);
    errors++;
  endtask

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 10);
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", read_value, '0);
      end else begin
        want = pending_results.pop_front();
        if (read_value !== want.read_value)
          report_mismatch("read_value", read_value, want.read_value);
        if (found !== want.found)
          report_mismatch("found", DATA_W'(found), DATA_W'(want.found));
        if (row_full !== want.row_full)
          report_mismatch("row_full", DATA_W'(row_full), DATA_W'(want.row_full));
        if (saturated !== want.saturated)
          report_mismatch("saturated", DATA_W'(saturated), DATA_W'(want.saturated));
        if (entry_total !== want.entry_total)
          report_mismatch("entry_total", DATA_W'(entry_total), DATA_W'(want.entry_total));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        !(in_valid || pending_results.size() != 0))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top: no beat for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_results.size());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic test_edge_values();
    send_op(KIND_SET, 6'd0, 10'd5, VAL_MAX);
    send_op(KIND_ADD, 6'd0, 10'd5, 32'sd1);
    send_op(KIND_SET, 6'd0, 10'd1, -32'sd5);
    send_op(KIND_ADD, 6'd0, 10'd9, VAL_MIN);
    send_op(KIND_ADD, 6'd0, 10'd9, -32'sd1);
    send_op(KIND_ADD, 6'd0, 10'd5, 32'sd0);
    send_op(KIND_ADD, 6'd0, 10'd7, 32'sd0);
    send_op(KIND_SET, 6'd0, 10'd7, 32'sd0);
    send_op(KIND_READ, 6'd0, 10'd1, 32'shdeadbeef);
    send_op(KIND_READ, 6'd0, 10'd3, VAL_ONE);
    send_op(KIND_SPARE, 6'd0, 10'd9, VAL_MAX);
    send_op(KIND_SET, 6'd63, 10'd1023, 32'sh12345678);
    send_op(KIND_READ, 6'd63, 10'd1023, 32'sd0);
    send_op(KIND_SET, 6'd0, 10'd0, -32'sd1);
  endtask

  // Descending columns: every insert lands at the front of the row.
  task automatic test_row_overflow();
    int i;
    for (i = 0; i < ROW_CAP; i++)
      send_op(KIND_SET, 6'd5, 10'(1000 - 7 * i), $urandom);
    send_op(KIND_SET, 6'd5, 10'd500, VAL_ONE);
    send_op(KIND_ADD, 6'd5, 10'd0, VAL_ONE);
    send_op(KIND_ADD, 6'd5, 10'd1000, VAL_MIN);
  endtask

  task automatic test_random_traffic(input int count);
    logic [KIND_W-1:0] k;
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] c;
    logic signed [DATA_W-1:0] v;
    int dice;
    repeat (count) begin
      dice = $urandom_range(99);
      if (dice < 40) k = KIND_SET;
      else if (dice < 72) k = KIND_ADD;
      else if (dice < 95) k = KIND_READ;
      else k = KIND_SPARE;
      r = ROW_W'(($urandom_range(99) < 75) ? $urandom_range(3) : $urandom_range(ROWS - 1));
      c = COL_W'(($urandom_range(99) < 70) ? $urandom_range(19) :
                 $urandom_range(COLUMNS - 1));
      dice = $urandom_range(99);
      if (dice < 10) begin
        v = '0;
      end else if (dice < 30) begin
        case ($urandom_range(3))
          0: v = VAL_MAX - $urandom_range(16'hffff);
          1: v = VAL_MIN + $urandom_range(16'hffff);
          2: v = VAL_ONE;
          default: v = -VAL_ONE;
        endcase
      end else begin
        v = $urandom;
      end
      send_op(k, r, c, v);
    end
  endtask

  task automatic test_back_to_back();
    calm = 1'b1;
    test_random_traffic(100);
    calm = 1'b0;
  endtask

  // Fill every row to capacity so the entry count reaches its top.
  task automatic test_fill_all_rows();
    int r;
    for (r = 0; r < ROWS; r++)
      while (row_count[r] < ROW_CAP)
        send_op(KIND_SET, ROW_W'(r), COL_W'($urandom_range(COLUMNS - 1)), $urandom);
  endtask

  task automatic test_full_table();
    test_random_traffic(60);
  endtask

  initial begin
    foreach (row_count[i]) row_count[i] = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_edge_values();
    test_row_overflow();
    test_random_traffic(150);
    test_back_to_back();
    test_fill_all_rows();
    test_full_table();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb_top: %0d set/add/read beats, %0d results checked", items_sent,
             results_checked);
    $display("tb_top: %0d inserts refused on full rows, %0d clipped sums, %0d entries stored",
             refused, clipped, stored_total);
    if (errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/srta_pkg.sv
src/srta_ram.sv
src/srta_ctrl.sv
src/sparse_row_table_accumulator_core.sv
tb/tb_top.sv
